>>> sv/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace unit.
// Used by sfr_ctrl, sfr_datapath and stream_find_replace_all_unit; no dependencies.
package sfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LEN   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPL
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_emit;
    logic repl_start;
    logic repl_emit;
    logic marker;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit_ok;
    logic full;
    logic hold;
    logic scan_last;
    logic rlen_zero;
    logic repl_last;
    logic fin;
  } stat_t;

endpackage

>>> sv/sfr_ctrl.sv
// Controller state machine for the stream find-and-replace unit.
// Depends on sfr_pkg; drives the command struct that sfr_datapath executes.
module sfr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sfr_pkg::stat_t stat,
  output sfr_pkg::cmd_t  cmd
);
  import sfr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.emit_ok) begin
          if (stat.full) begin
            cmd.repl_start = 1'b1;
            if (stat.rlen_zero) begin
              // A deleted match at the end of a string still closes it.
              cmd.marker = stat.fin;
              state_nxt  = ST_IDLE;
            end else begin
              state_nxt = ST_REPL;
            end
          end else if (stat.hold) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.scan_emit = 1'b1;
            if (stat.scan_last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_REPL: begin
        if (stat.emit_ok) begin
          cmd.repl_emit = 1'b1;
          if (stat.repl_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.scan_emit, cmd.repl_emit, cmd.marker}))
    else $error("more than one result issued in a cycle");

  a_repl_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPL) |-> !stat.rlen_zero)
    else $error("replacement run entered with empty replacement");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && !stat.emit_ok) |=> (state_r == $past(state_r)))
    else $error("controller advanced while the output was stalled");

endmodule

>>> sv/sfr_datapath.sv
// Datapath of the stream find-and-replace unit: configuration registers, held-byte
// shift buffer, pattern compare, replacement index and output register. Depends on sfr_pkg.
module sfr_datapath #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [sfr_pkg::BYTE_W-1:0]       in_data_byte,
  input  logic                             in_string_final,
  input  sfr_pkg::cmd_t                    cmd,
  output sfr_pkg::stat_t                   stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sfr_pkg::BYTE_W-1:0]       out_byte,
  output logic                             out_byte_present,
  output logic                             out_run_last,
  output logic                             out_string_done
);
  import sfr_pkg::*;

  localparam int HOLD_D = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
  localparam int REPL_D = (MAX_REPLACEMENT < 8) ? MAX_REPLACEMENT : 8;
  localparam int CW     = $clog2(HOLD_D + 1);
  localparam int RCW    = $clog2(REPL_D + 1);
  localparam int RKW    = (REPL_D > 1) ? $clog2(REPL_D) : 1;

  logic [CFG_DATA_W-1:0] pat_r;
  logic [LEN_W-1:0]      plen_cfg_r;
  logic [CFG_DATA_W-1:0] rep_r;
  logic [LEN_W-1:0]      rlen_cfg_r;

  logic [BYTE_W-1:0] hold_r   [HOLD_D];
  logic [BYTE_W-1:0] hold_nxt [HOLD_D];
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic              fin_r;
  logic [RKW-1:0]    rk_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_present_r;
  logic              out_last_r;
  logic              out_done_r;

  logic [CW-1:0]     plen;
  logic [RCW-1:0]    rlen;
  logic [CW-1:0]     hc;
  logic              m0;
  logic              m1;
  logic [BYTE_W-1:0] rbyte;
  logic              emit_ok;

  assign plen = (plen_cfg_r > LEN_W'(HOLD_D)) ? CW'(HOLD_D) : CW'(plen_cfg_r);
  assign rlen = (rlen_cfg_r > LEN_W'(REPL_D)) ? RCW'(REPL_D) : RCW'(rlen_cfg_r);
  assign hc   = (cnt_r >= plen) ? '0 : cnt_r;
  assign emit_ok = !out_valid_r || out_ready;

  // m0: buffered bytes match the pattern prefix; m1: the same after dropping the front byte.
  always_comb begin
    m0    = 1'b1;
    m1    = 1'b1;
    rbyte = '0;
    for (int k = 0; k < HOLD_D; k++) begin
      if (CW'(k) < cnt_r && hold_r[k] != pat_r[BYTE_W*k +: BYTE_W]) begin
        m0 = 1'b0;
      end
    end
    for (int k = 0; k < HOLD_D - 1; k++) begin
      if (CW'(k + 1) < cnt_r && hold_r[k+1] != pat_r[BYTE_W*k +: BYTE_W]) begin
        m1 = 1'b0;
      end
    end
    for (int i = 0; i < REPL_D; i++) begin
      if (rk_r == RKW'(i)) begin
        rbyte = rep_r[BYTE_W*i +: BYTE_W];
      end
    end
  end

  always_comb begin
    stat.emit_ok   = emit_ok;
    stat.full      = (cnt_r != '0) && (cnt_r == plen) && m0;
    stat.hold      = !fin_r && (cnt_r != '0) && (cnt_r < plen) && m0;
    stat.scan_last = (cnt_r == CW'(1)) || (!fin_r && m1);
    stat.rlen_zero = (rlen == '0);
    stat.repl_last = ((RCW'(rk_r) + RCW'(1)) == rlen);
    stat.fin       = fin_r;
  end

  always_comb begin
    hold_nxt = hold_r;
    cnt_nxt  = cnt_r;
    if (cmd.load) begin
      for (int i = 0; i < HOLD_D; i++) begin
        if (hc == CW'(i)) begin
          hold_nxt[i] = in_data_byte;
        end
      end
      cnt_nxt = hc + CW'(1);
    end else if (cmd.scan_emit) begin
      for (int i = 0; i < HOLD_D - 1; i++) begin
        hold_nxt[i] = hold_r[i+1];
      end
      cnt_nxt = cnt_r - CW'(1);
    end else if (cmd.repl_start) begin
      cnt_nxt = '0;
    end
    // Any change of the pattern drops the held bytes.
    if (cfg_we && (cfg_index == REG_PATTERN_BYTES || cfg_index == REG_PATTERN_LENGTH)) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r      <= '0;
      plen_cfg_r <= '0;
      rep_r      <= '0;
      rlen_cfg_r <= '0;
      cnt_r      <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_BYTES:     pat_r      <= cfg_wdata;
          REG_PATTERN_LENGTH:    plen_cfg_r <= cfg_wdata[LEN_W-1:0];
          REG_REPLACEMENT_BYTES: rep_r      <= cfg_wdata;
          REG_REPLACEMENT_LEN:   rlen_cfg_r <= cfg_wdata[LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    if (cmd.load) begin
      fin_r <= in_string_final;
    end
    if (cmd.repl_start) begin
      rk_r <= '0;
    end else if (cmd.repl_emit) begin
      rk_r <= rk_r + RKW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.scan_emit || cmd.repl_emit || cmd.marker) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_emit) begin
      out_byte_r    <= hold_r[0];
      out_present_r <= 1'b1;
      out_last_r    <= stat.scan_last;
      out_done_r    <= stat.scan_last && fin_r;
    end else if (cmd.repl_emit) begin
      out_byte_r    <= rbyte;
      out_present_r <= 1'b1;
      out_last_r    <= stat.repl_last;
      out_done_r    <= stat.repl_last && fin_r;
    end else if (cmd.marker) begin
      out_byte_r    <= '0;
      out_present_r <= 1'b0;
      out_last_r    <= 1'b1;
      out_done_r    <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_byte_present = out_present_r;
  assign out_run_last     = out_last_r;
  assign out_string_done  = out_done_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_emit || cmd.repl_emit || cmd.marker) |-> emit_ok)
    else $error("output register overwritten before it was taken");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(HOLD_D))
    else $error("held count beyond buffer depth");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> out_last_r)
    else $error("string end flagged on a result that is not the last of its item");

endmodule

>>> sv/stream_find_replace_all_unit.sv
// Top level of the stream find-and-replace-all unit.
// Depends on sfr_pkg and instantiates sfr_ctrl and sfr_datapath.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | in_data_byte, in_string_final
//   out_    | output    | out_valid / out_ready| out_byte, out_byte_present,
//           |           |                      | out_run_last, out_string_done
//   cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// An item is loaded in idle, then the scan and replacement states issue one result per
// cycle while the output is not stalled. A full match starts its replacement run from
// the scan; an item that only holds bytes or drops a match with no marker emits none.
// The held-byte scan and the replacement run share one output register.
// Synchronous active-low reset clears the configuration and the held count.
// With a result waiting and out_ready low, the scan pauses; idle still takes items.
module stream_find_replace_all_unit #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sfr_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                           in_string_final,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sfr_pkg::BYTE_W-1:0]     out_byte,
  output logic                           out_byte_present,
  output logic                           out_run_last,
  output logic                           out_string_done
);
  import sfr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfr_datapath #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_data_byte     (in_data_byte),
    .in_string_final  (in_string_final),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_present (out_byte_present),
    .out_run_last     (out_run_last),
    .out_string_done  (out_string_done)
  );

endmodule
